// ===== rtl/core/arnt_pkg.sv =====
// ============================================================================
// arnt_pkg: shared types and helpers for the ACK record number tracker
// Holds command and result layouts, operation and result codes, and the
// record pair type used by the store and the compare unit.
// ============================================================================
package arnt_pkg;

    // Default depth of the record list
    localparam int MAX_RECORDS_DEF = 8;

    typedef enum logic [1:0] {
        OP_SAVE   = 2'd0,
        OP_EMIT   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_UNUSED = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_SAVE  = 2'd0,
        KIND_ENTRY = 2'd1,
        KIND_EMPTY = 2'd2,
        KIND_CLEAR = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        SAVE_APPENDED  = 2'd0,
        SAVE_DUPLICATE = 2'd1,
        SAVE_EVICTED   = 2'd2,
        SAVE_RESERVED  = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } t_state;

    // Epoch sits in the upper half, so a plain compare orders pairs correctly
    typedef struct packed {
        logic [63:0] epoch;
        logic [63:0] seq_num;
    } t_pair;

    typedef struct packed {
        t_opcode     opcode;
        logic [63:0] epoch;
        logic [63:0] seq_num;
    } t_cmd;

    typedef struct packed {
        t_kind       kind;
        t_status     status;
        logic [63:0] out_epoch;
        logic [63:0] out_seq_num;
        logic        last;
        logic [3:0]  record_count;
        logic [7:0]  list_bytes;
        logic        start_timer;
    } t_result;

    typedef struct packed {
        logic eq;
        logic lt;
    } t_cmp_flags;

    function automatic t_result make_result(
        input t_kind      kind,
        input t_status    status,
        input t_pair      pair,
        input logic       last,
        input logic [3:0] count,
        input logic       start_timer
    );
        t_result res;
        res.kind         = kind;
        res.status       = status;
        res.out_epoch    = pair.epoch;
        res.out_seq_num  = pair.seq_num;
        res.last         = last;
        res.record_count = count;
        res.list_bytes   = {count, 4'h0};
        res.start_timer  = start_timer;
        return res;
    endfunction

endpackage

// ===== rtl/core/arnt_store.sv =====
// ============================================================================
// arnt_store: record pair memory
// One write port and one read port with registered read data.
// ============================================================================
module arnt_store #(
    parameter int DEPTH = arnt_pkg::MAX_RECORDS_DEF,
    parameter int AW    = 3
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  arnt_pkg::t_pair  i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output arnt_pkg::t_pair  o_rd_data
);

    arnt_pkg::t_pair r_mem [DEPTH];
    arnt_pkg::t_pair r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/arnt_cmp.sv =====
// ============================================================================
// arnt_cmp: shared pair comparator
// Equality and ordering of two (epoch, sequence) pairs.
// ============================================================================
module arnt_cmp (
    input  arnt_pkg::t_pair      i_a,
    input  arnt_pkg::t_pair      i_b,
    output arnt_pkg::t_cmp_flags o_flags
);

    // Epoch in the upper bits makes this the lexicographic order
    assign o_flags.eq = (i_a == i_b);
    assign o_flags.lt = (i_a < i_b);

endmodule

// ===== rtl/core/ack_record_number_tracker.sv =====
// ============================================================================
// ack_record_number_tracker: bounded list of received record numbers
// Saves (epoch, sequence) pairs without duplicates, evicting the oldest when
// full, emits the list in ascending order, and clears it on request.
// ============================================================================
// Clear and emit of an empty list: result the cycle after acceptance, busy
//   never rises; an unused opcode is taken at once and gives no result.
// Save: busy while the held entries are read (one read per cycle), then one
//   drain and one finish step (only the finish when empty), status the following cycle.
// Emit: one pass per entry held, each a full scan over the single comparator,
//   one entry strobed after each pass. Reset empties the list, disarms the timer.
module ack_record_number_tracker #(
    parameter int MAX_RECORDS = arnt_pkg::MAX_RECORDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  arnt_pkg::t_cmd    i_cmd,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    output logic              o_strobe,
    output arnt_pkg::t_result o_result
);

    // Address width of the list, count width that can hold the depth itself
    localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int SW = CW + 1;

    // ------------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------------
    arnt_pkg::t_state  r_state, n_state;
    arnt_pkg::t_opcode r_op, n_op;
    arnt_pkg::t_pair   r_req, n_req;        // pair of the save transaction
    arnt_pkg::t_pair   r_best, n_best;      // running minimum of an emit pass
    logic [AW-1:0]     r_best_idx, n_best_idx;
    logic              r_best_vld, n_best_vld;
    logic [MAX_RECORDS-1:0] r_used, n_used; // entries already emitted
    logic [CW-1:0]     r_idx, n_idx;        // next logical entry to read
    logic              r_chk, n_chk;        // read data valid this cycle
    logic [AW-1:0]     r_chk_idx, n_chk_idx;
    logic [CW-1:0]     r_k, n_k;            // emit pass number
    logic              r_dup, n_dup;
    logic [CW-1:0]     r_count, n_count;    // entries held
    logic [AW-1:0]     r_head, n_head;      // physical slot of the oldest entry
    logic              r_armed, n_armed;
    logic              r_active, n_active;
    arnt_pkg::t_result r_out, n_out;
    logic              r_out_vld, n_out_vld;

    // Store and comparator hookup
    logic                 rd_en, wr_en;
    logic [AW-1:0]        rd_addr, wr_addr;
    arnt_pkg::t_pair      rd_data;
    arnt_pkg::t_pair      cmp_ref;
    arnt_pkg::t_cmp_flags cmp_flags;

    logic issue, scan_end, last_pass, full;

    // Map a logical index onto the ring, given the head slot
    function automatic logic [AW-1:0] ring_addr(input logic [SW-1:0] sum);
        logic [AW-1:0] addr;
        if (sum >= SW'(MAX_RECORDS)) begin
            addr = AW'(sum - SW'(MAX_RECORDS));
        end else begin
            addr = AW'(sum);
        end
        return addr;
    endfunction

    arnt_store #(
        .DEPTH (MAX_RECORDS),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_req),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Save compares against the incoming pair, emit against the running best
    assign cmp_ref = (r_op == arnt_pkg::OP_SAVE) ? r_req : r_best;

    arnt_cmp u_cmp (
        .i_a     (rd_data),
        .i_b     (cmp_ref),
        .o_flags (cmp_flags)
    );

    // ------------------------------------------------------------------------
    // Scan control: one read issued per cycle, its data checked in the cycle after
    // ------------------------------------------------------------------------
    assign issue     = (r_state == arnt_pkg::ST_SCAN) && (r_idx < r_count);
    assign scan_end  = (r_state == arnt_pkg::ST_SCAN) && !issue && !r_chk;
    assign last_pass = ((r_k + CW'(1)) == r_count);
    assign full      = (r_count == CW'(MAX_RECORDS));
    assign busy      = (r_state != arnt_pkg::ST_IDLE);

    assign rd_en   = issue;
    assign rd_addr = ring_addr(SW'(r_head) + SW'(r_idx));

    // ------------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            arnt_pkg::ST_IDLE: begin
                if (start) begin
                    if ((i_cmd.opcode == arnt_pkg::OP_SAVE) ||
                        ((i_cmd.opcode == arnt_pkg::OP_EMIT) && (r_count != '0))) begin
                        n_state = arnt_pkg::ST_SCAN;
                    end
                end
            end
            arnt_pkg::ST_SCAN: begin
                if (scan_end && ((r_op != arnt_pkg::OP_EMIT) || last_pass)) begin
                    n_state = arnt_pkg::ST_IDLE;
                end
            end
            default: n_state = arnt_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // Datapath and outputs
    // ------------------------------------------------------------------------
    always_comb begin
        logic [CW-1:0]     cnt_after;
        arnt_pkg::t_status sts;
        logic              st;

        n_op       = r_op;
        n_req      = r_req;
        n_best     = r_best;
        n_best_idx = r_best_idx;
        n_best_vld = r_best_vld;
        n_used     = r_used;
        n_idx      = r_idx;
        n_chk      = 1'b0;
        n_chk_idx  = r_chk_idx;
        n_k        = r_k;
        n_dup      = r_dup;
        n_count    = r_count;
        n_head     = r_head;
        n_armed    = r_armed;
        n_active   = r_active;
        n_out      = r_out;
        n_out_vld  = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = full ? r_head : ring_addr(SW'(r_head) + SW'(r_count));
        cnt_after  = r_count;
        sts        = arnt_pkg::SAVE_APPENDED;
        st         = 1'b0;

        // The user must write the configuration only while idle; the block does not enforce it
        if (i_cfg_we) begin
            n_active = i_cfg_wdata;
        end

        case (r_state)
            arnt_pkg::ST_IDLE: begin
                if (start) begin
                    n_op       = i_cmd.opcode;
                    n_req      = '{epoch: i_cmd.epoch, seq_num: i_cmd.seq_num};
                    n_idx      = '0;
                    n_k        = '0;
                    n_dup      = 1'b0;
                    n_best_vld = 1'b0;
                    n_used     = '0;
                    case (i_cmd.opcode)
                        arnt_pkg::OP_CLEAR: begin
                            n_count   = '0;
                            n_head    = '0;
                            n_armed   = 1'b0;
                            n_out     = arnt_pkg::make_result(arnt_pkg::KIND_CLEAR,
                                            arnt_pkg::SAVE_APPENDED, '0, 1'b1, 4'h0, 1'b0);
                            n_out_vld = 1'b1;
                        end
                        arnt_pkg::OP_EMIT: begin
                            if (r_count == '0) begin
                                n_out     = arnt_pkg::make_result(arnt_pkg::KIND_EMPTY,
                                                arnt_pkg::SAVE_APPENDED, '0, 1'b1, 4'h0, 1'b0);
                                n_out_vld = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            arnt_pkg::ST_SCAN: begin
                if (issue) begin
                    n_idx = r_idx + CW'(1);
                end
                n_chk     = issue;
                n_chk_idx = r_idx[AW-1:0];

                if (r_chk) begin
                    if (r_op == arnt_pkg::OP_SAVE) begin
                        if (cmp_flags.eq) begin
                            n_dup = 1'b1;
                        end
                    end else if (!r_used[r_chk_idx] && (!r_best_vld || cmp_flags.lt)) begin
                        n_best     = rd_data;
                        n_best_idx = r_chk_idx;
                        n_best_vld = 1'b1;
                    end
                end

                if (scan_end) begin
                    case (r_op)
                        arnt_pkg::OP_SAVE: begin
                            if (r_dup) begin
                                sts = arnt_pkg::SAVE_DUPLICATE;
                            end else begin
                                wr_en = 1'b1;
                                if (full) begin
                                    // Oldest slot takes the new pair, head moves on
                                    sts    = arnt_pkg::SAVE_EVICTED;
                                    n_head = (r_head == AW'(MAX_RECORDS - 1)) ?
                                             '0 : r_head + AW'(1);
                                end else begin
                                    cnt_after = r_count + CW'(1);
                                end
                                if (r_active && !r_armed) begin
                                    st      = 1'b1;
                                    n_armed = 1'b1;
                                end
                            end
                            n_count   = cnt_after;
                            n_out     = arnt_pkg::make_result(arnt_pkg::KIND_SAVE, sts, '0,
                                            1'b1, 4'(cnt_after), st);
                            n_out_vld = 1'b1;
                        end
                        arnt_pkg::OP_EMIT: begin
                            n_used[r_best_idx] = 1'b1;
                            n_out      = arnt_pkg::make_result(arnt_pkg::KIND_ENTRY,
                                             arnt_pkg::SAVE_APPENDED, r_best, last_pass,
                                             4'(r_count), 1'b0);
                            n_out_vld  = 1'b1;
                            // Restart the scan for the next smallest pair
                            n_idx      = '0;
                            n_best_vld = 1'b0;
                            n_k        = r_k + CW'(1);
                        end
                        default: ;
                    endcase
                end
            end

            default: ;
        endcase
    end

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= arnt_pkg::ST_IDLE;
            r_op       <= arnt_pkg::OP_SAVE;
            r_best_vld <= 1'b0;
            r_used     <= '0;
            r_idx      <= '0;
            r_chk      <= 1'b0;
            r_k        <= '0;
            r_dup      <= 1'b0;
            r_count    <= '0;
            r_head     <= '0;
            r_armed    <= 1'b0;
            r_active   <= 1'b1;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_op       <= n_op;
            r_best_vld <= n_best_vld;
            r_used     <= n_used;
            r_idx      <= n_idx;
            r_chk      <= n_chk;
            r_k        <= n_k;
            r_dup      <= n_dup;
            r_count    <= n_count;
            r_head     <= n_head;
            r_armed    <= n_armed;
            r_active   <= n_active;
            r_out_vld  <= n_out_vld;
        end
    end

    // Payload: hold without reset
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_chk_idx  <= n_chk_idx;
        r_out      <= n_out;
    end

    assign o_strobe = r_out_vld;
    assign o_result = r_out;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_RECORDS))
        else $error("entry count beyond list depth");

    a_clear_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_cmd.opcode == arnt_pkg::OP_CLEAR)
        |=> o_strobe && (o_result.kind == arnt_pkg::KIND_CLEAR) && (r_count == '0))
        else $error("clear transaction did not complete next cycle");

    a_not_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last |-> busy)
        else $error("intermediate result while idle");

    a_timer_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.start_timer
        |-> r_armed && (o_result.kind == arnt_pkg::KIND_SAVE))
        else $error("timer start without armed flag");

endmodule

// ===== bench/ack_record_number_tracker_tb.sv =====
// ============================================================================
// ack_record_number_tracker_tb: self-checking bench for the record list
// Drives save, emit, clear and unused commands through the start/busy
// handshake, predicts every result strobe with an in-bench list model and
// compares field by field. The dtls13_active register is rewritten between
// phases while the block is idle.
// ============================================================================
module ack_record_number_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import arnt_pkg::*;

    localparam int DEPTH        = MAX_RECORDS_DEF;
    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    // Cycles to let pass once nothing is outstanding, before a register
    // write and before the final verdict
    localparam int SETTLE       = 4;
    localparam int DRAIN        = 40;
    // Watchdog limit on cycles without a command or result transaction
    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 24;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the record list, the timer flag and the
    // register, plus the queue of results still to arrive
    // ------------------------------------------------------------------------
    class record_list_checker;
        t_pair   held [DEPTH];
        int      held_count;
        bit      timer_armed;
        bit      dtls13;
        t_result pending_results [$];
        int      failures;

        function new();
            held_count  = 0;
            timer_armed = 1'b0;
            dtls13      = 1'b1;
            failures    = 0;
        endfunction

        function void set_dtls13(input bit value);
            dtls13 = value;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void push_result(input t_kind kind, input t_status status,
                                  input t_pair pair, input logic last,
                                  input logic start_timer);
            t_result res;
            res.kind         = kind;
            res.status       = status;
            res.out_epoch    = pair.epoch;
            res.out_seq_num  = pair.seq_num;
            res.last         = last;
            res.record_count = 4'(held_count);
            res.list_bytes   = 8'(held_count * 16);
            res.start_timer  = start_timer;
            pending_results.push_back(res);
        endfunction

        // Update the list for one accepted command and queue its results
        function void accept_cmd(input t_cmd cmd);
            t_pair   pair;
            t_pair   sorted [DEPTH];
            t_pair   key;
            t_status status;
            bit      dup;
            bit      tmr;
            int      i;
            int      j;

            pair.epoch   = cmd.epoch;
            pair.seq_num = cmd.seq_num;
            case (cmd.opcode)
                OP_SAVE: begin
                    dup = 1'b0;
                    for (i = 0; i < held_count; i++)
                        if (held[i] == pair)
                            dup = 1'b1;
                    if (dup) begin
                        push_result(KIND_SAVE, SAVE_DUPLICATE, '0, 1'b1, 1'b0);
                    end else begin
                        if (held_count < DEPTH) begin
                            held[held_count] = pair;
                            held_count++;
                            status = SAVE_APPENDED;
                        end else begin
                            for (i = 1; i < DEPTH; i++)
                                held[i - 1] = held[i];
                            held[DEPTH - 1] = pair;
                            status = SAVE_EVICTED;
                        end
                        tmr = dtls13 && !timer_armed;
                        if (tmr)
                            timer_armed = 1'b1;
                        push_result(KIND_SAVE, status, '0, 1'b1, tmr);
                    end
                end
                OP_EMIT: begin
                    if (held_count == 0) begin
                        push_result(KIND_EMPTY, SAVE_APPENDED, '0, 1'b1, 1'b0);
                    end else begin
                        // Epoch is the upper half, so a 128-bit compare orders pairs
                        for (i = 0; i < held_count; i++) begin
                            key = held[i];
                            j   = i;
                            while (j > 0 && sorted[j - 1] > key) begin
                                sorted[j] = sorted[j - 1];
                                j--;
                            end
                            sorted[j] = key;
                        end
                        for (i = 0; i < held_count; i++)
                            push_result(KIND_ENTRY, SAVE_APPENDED, sorted[i],
                                        i == held_count - 1, 1'b0);
                    end
                end
                OP_CLEAR: begin
                    held_count  = 0;
                    timer_armed = 1'b0;
                    push_result(KIND_CLEAR, SAVE_APPENDED, '0, 1'b1, 1'b0);
                end
                default: ;
            endcase
        endfunction

        function void cmp_field(input string name, input logic [63:0] exp_val,
                                input logic [63:0] act_val);
            if (exp_val !== act_val) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, exp_val, act_val);
                failures++;
            end
        endfunction

        function void check_result(input t_result act);
            t_result exp_res;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d",
                         $time, act.kind);
                failures++;
                return;
            end
            exp_res = pending_results.pop_front();
            cmp_field("kind",         exp_res.kind,         act.kind);
            cmp_field("status",       exp_res.status,       act.status);
            cmp_field("out_epoch",    exp_res.out_epoch,    act.out_epoch);
            cmp_field("out_seq_num",  exp_res.out_seq_num,  act.out_seq_num);
            cmp_field("last",         exp_res.last,         act.last);
            cmp_field("record_count", exp_res.record_count, act.record_count);
            cmp_field("list_bytes",   exp_res.list_bytes,   act.list_bytes);
            cmp_field("start_timer",  exp_res.start_timer,  act.start_timer);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block inputs, all at known values from time zero
    // ------------------------------------------------------------------------
    logic    i_clk       = 1'b0;
    logic    i_rst_n     = 1'b0;
    logic    start       = 1'b0;
    t_cmd    cmd         = '0;
    logic    i_cfg_we    = 1'b0;
    logic    i_cfg_wdata = 1'b0;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    record_list_checker tracker = new();

    // Sender idling switch: off for the long back-to-back stretch
    bit idle_enable = 1'b1;
    int quiet_cycles = 0;

    ack_record_number_tracker #(
        .MAX_RECORDS (DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Sample results at the edge that ends their strobe cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            tracker.check_result(o_result);
    end

    // Watchdog: count cycles with neither a command nor a result transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Present one command and hold it until the block takes it; start stays
    // high into the next command unless the sender decides to idle
    task automatic send_cmd(input t_opcode op, input logic [63:0] ep,
                            input logic [63:0] sq);
        t_cmd c;
        int   gap;
        gap = 0;
        if (idle_enable && $urandom_range(0, 99) < 15)
            gap = $urandom_range(1, 6);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        c.opcode  = op;
        c.epoch   = ep;
        c.seq_num = sq;
        start <= 1'b1;
        cmd   <= c;
        do @(posedge i_clk); while (busy);
        tracker.accept_cmd(c);
    endtask

    // Write the register only once every outstanding result has arrived
    task automatic write_dtls13(input logic value);
        start <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.set_dtls13(value);
    endtask

    // Mix of small values, full-width noise, near-maximum and one-hot words
    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 3))
            0:       return 64'($urandom_range(0, 3));
            1:       return {$urandom(), $urandom()};
            2:       return ~64'($urandom_range(0, 3));
            default: return 64'd1 << $urandom_range(0, 63);
        endcase
    endfunction

    // One random phase: mostly saves (fresh and repeated pairs) with emits,
    // and now and then a clear or an unused opcode
    task automatic random_phase(input int n_items);
        int          counted;
        int          pick;
        int          idx;
        logic [63:0] ep;
        logic [63:0] sq;
        counted = 0;
        while (counted < n_items) begin
            pick = $urandom_range(0, 99);
            ep   = rand_word();
            sq   = rand_word();
            if (pick < 52) begin
                send_cmd(OP_SAVE, ep, sq);
            end else if (pick < 70) begin
                // Repeat a held pair to hit the duplicate path
                if (tracker.held_count > 0) begin
                    idx = $urandom_range(0, tracker.held_count - 1);
                    ep  = tracker.held[idx].epoch;
                    sq  = tracker.held[idx].seq_num;
                end
                send_cmd(OP_SAVE, ep, sq);
            end else if (pick < 86) begin
                send_cmd(OP_EMIT, ep, sq);
            end else if (pick < 94) begin
                send_cmd(OP_CLEAR, ep, sq);
            end else begin
                // Ignored by the block: do not count it
                send_cmd(OP_UNUSED, ep, sq);
                counted--;
            end
            counted++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty list, first save starting the timer, extreme pairs,
        // duplicate drop, fill to depth, eviction, sorted emit with epoch ties
        send_cmd(OP_EMIT,  64'd0, 64'd0);
        send_cmd(OP_CLEAR, 64'd0, 64'd0);
        send_cmd(OP_SAVE,  64'd0, 64'd0);
        send_cmd(OP_SAVE,  '1, '1);
        send_cmd(OP_SAVE,  64'd0, 64'd0);
        send_cmd(OP_SAVE,  64'd5, 64'd9);
        send_cmd(OP_SAVE,  64'd5, 64'd3);
        send_cmd(OP_SAVE,  64'd0, '1);
        send_cmd(OP_SAVE,  '1, 64'd0);
        send_cmd(OP_SAVE,  64'h8000_0000_0000_0000, 64'd1);
        send_cmd(OP_SAVE,  64'd2, 64'd2);
        send_cmd(OP_EMIT,  '1, '1);
        send_cmd(OP_SAVE,  64'd7, 64'd7);
        // The first pair has just been evicted, so it is fresh again
        send_cmd(OP_SAVE,  64'd0, 64'd0);
        send_cmd(OP_UNUSED, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
        send_cmd(OP_EMIT,  64'd0, 64'd0);
        send_cmd(OP_CLEAR, '1, '1);
        send_cmd(OP_SAVE,  64'd3, 64'd4);
        send_cmd(OP_SAVE,  64'd3, 64'd5);
        send_cmd(OP_CLEAR, 64'd0, 64'd0);

        // Timer start disabled: a save after a clear must not flag it
        write_dtls13(1'b0);
        send_cmd(OP_SAVE,  64'd1, 64'd1);
        send_cmd(OP_EMIT,  64'd0, 64'd0);
        write_dtls13(1'b1);
        // Timer still disarmed, so the next fresh save starts it
        send_cmd(OP_SAVE,  64'd1, 64'd2);
        send_cmd(OP_CLEAR, 64'd0, 64'd0);

        random_phase(PHASE_ITEMS);

        // Long back-to-back stretch with timer start disabled
        write_dtls13(1'b0);
        idle_enable = 1'b0;
        random_phase(PHASE_ITEMS);
        idle_enable = 1'b1;

        write_dtls13(1'($urandom_range(0, 1)));
        random_phase(PHASE_ITEMS);

        write_dtls13(1'b1);
        random_phase(PHASE_ITEMS);

        // Drain: drop start, wait for every expected result, then settle
        start <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/arnt_pkg.sv
rtl/core/arnt_store.sv
rtl/core/arnt_cmp.sv
rtl/core/ack_record_number_tracker.sv
bench/ack_record_number_tracker_tb.sv
